[hw/rtl/wia_pkg.sv]
// Shared constants and types for the weighted intensity accumulator.
package wia_pkg;

  localparam int COORD_W     = 7;
  localparam int SAMP_W      = 16;
  localparam int WEIGHT_W    = 16;
  localparam int MAG_W       = 32;
  localparam int TERM_W      = 31;
  localparam int PROD_W      = 48;
  localparam int PIX_W       = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_WEIGHT = 1'b0;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  typedef struct packed {
    logic is_read;
    logic start;
  } wia_ctl_t;

endpackage

[hw/rtl/weighted_intensity_accumulator_core.sv]
// Weighted intensity accumulator: a GRID_SIZE x GRID_SIZE store of 40-bit
// saturating intensity sums. An accumulate word adds weight*(re^2+im^2)>>16 to
// its pixel (or overwrites it when start_req is set); a readout word returns
// the pixel at the quadrant-swapped position. One word is taken per clock in
// steady state unless a readout is held by out_stall, accumulates to the same
// pixel included, since the store does a read-modify-write with forwarding of
// the word just written. A readout passes front stages one and two, the queue,
// the back stage and the result register. After reset the store is cleared one
// pixel per clock with in_stall high; the weight register can still be written.
module weighted_intensity_accumulator_core #(
  parameter int GRID_SIZE = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [wia_pkg::COORD_W-1:0]          in_row,
  input  logic [wia_pkg::COORD_W-1:0]          in_col,
  input  logic signed [wia_pkg::SAMP_W-1:0]    in_re,
  input  logic signed [wia_pkg::SAMP_W-1:0]    in_im,
  input  logic                                 in_start_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wia_pkg::PIX_W-1:0]            out_pixel,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wia_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [wia_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [wia_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import wia_pkg::*;

  localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                cfg_wr;

  logic              push_valid, q_full, q_empty, q_pop, clearing;
  wia_ctl_t          push_ctl, head_ctl;
  logic [ADDR_W-1:0] push_addr, head_addr;
  logic [TERM_W-1:0] push_term, head_term;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    weight_nxt = weight_r;
    if (cfg_wr && paddr[2] == REG_WEIGHT) weight_nxt = pwdata[WEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) weight_r <= '0;
    else weight_r <= weight_nxt;
  end

  assign prdata = (paddr[2] == REG_WEIGHT) ? APB_DATA_W'(weight_r) : '0;

  wia_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_re       (in_re),
    .in_im       (in_im),
    .in_start_req(in_start_req),
    .weight      (weight_r),
    .hold        (clearing),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_ctl    (push_ctl),
    .push_addr   (push_addr),
    .push_term   (push_term)
  );

  wia_queue #(
    .ADDR_W(ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ctl  (push_ctl),
    .push_addr (push_addr),
    .push_term (push_term),
    .full      (q_full),
    .empty     (q_empty),
    .pop       (q_pop),
    .head_ctl  (head_ctl),
    .head_addr (head_addr),
    .head_term (head_term)
  );

  wia_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .head_ctl (head_ctl),
    .head_addr(head_addr),
    .head_term(head_term),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel(out_pixel)
  );

endmodule

[hw/rtl/wia_front.sv]
// Front end: takes input words, wraps coordinates, forms pixel address and weighted term.
module wia_front #(
  parameter int GRID_SIZE = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [wia_pkg::COORD_W-1:0]          in_row,
  input  logic [wia_pkg::COORD_W-1:0]          in_col,
  input  logic signed [wia_pkg::SAMP_W-1:0]    in_re,
  input  logic signed [wia_pkg::SAMP_W-1:0]    in_im,
  input  logic                                 in_start_req,
  input  logic [wia_pkg::WEIGHT_W-1:0]         weight,
  input  logic                                 hold,
  input  logic                                 q_full,
  output logic                                 push_valid,
  output wia_pkg::wia_ctl_t                    push_ctl,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] push_addr,
  output logic [wia_pkg::TERM_W-1:0]           push_term
);
  import wia_pkg::*;

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int MW     = ((CW > COORD_W) ? CW : COORD_W) + 1;
  localparam int NSUB   = ((1 << COORD_W) - 1) / GRID_SIZE;
  localparam int HALF   = GRID_SIZE / 2;

  function automatic logic [MW-1:0] wrap_coord(input logic [MW-1:0] v);
    logic [MW-1:0] r;
    r = v;
    for (int k = 0; k < NSUB; k++) begin
      if (r >= MW'(GRID_SIZE)) r = r - MW'(GRID_SIZE);
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] half_shift(input logic [MW-1:0] v);
    logic [MW-1:0] r;
    r = v + MW'(HALF);
    if (r >= MW'(GRID_SIZE)) r = r - MW'(GRID_SIZE);
    return r;
  endfunction

  logic               f1_valid_r, f1_valid_nxt;
  wia_ctl_t           f1_ctl_r;
  logic [CW-1:0]      f1_row_r, f1_col_r;
  logic [MAG_W-1:0]   f1_mag_r;
  logic               f2_valid_r, f2_valid_nxt;
  wia_ctl_t           f2_ctl_r;
  logic [ADDR_W-1:0]  f2_addr_r;
  logic [TERM_W-1:0]  f2_term_r;

  logic               f1_adv, f2_adv, accept;
  logic [MW-1:0]      row_w, col_w, row_sel, col_sel;
  logic signed [MAG_W-1:0] sq_re, sq_im;
  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  addr;
  wia_ctl_t           ctl_in;

  assign f2_adv   = !f2_valid_r || !q_full;
  assign f1_adv   = !f1_valid_r || f2_adv;
  assign in_stall = hold || !f1_adv;
  assign accept   = in_valid && !in_stall;

  // stage one: coordinates and squared magnitude
  always_comb begin
    row_w = wrap_coord(MW'(in_row));
    col_w = wrap_coord(MW'(in_col));
    if (in_op == OP_READ) begin
      row_sel = half_shift(row_w);
      col_sel = half_shift(col_w);
    end else begin
      row_sel = row_w;
      col_sel = col_w;
    end
    ctl_in.is_read = (in_op == OP_READ);
    ctl_in.start   = in_start_req;
  end

  assign sq_re = in_re * in_re;
  assign sq_im = in_im * in_im;
  assign mag   = $unsigned(sq_re) + $unsigned(sq_im);

  // stage two: address and weighted term
  assign addr = ADDR_W'(f1_row_r) * ADDR_W'(GRID_SIZE) + ADDR_W'(f1_col_r);
  assign prod = PROD_W'(weight) * PROD_W'(f1_mag_r);

  assign f1_valid_nxt = f1_adv ? accept : f1_valid_r;
  assign f2_valid_nxt = f2_adv ? f1_valid_r : f2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
      f2_valid_r <= f2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv) begin
      f1_ctl_r <= ctl_in;
      f1_row_r <= CW'(row_sel);
      f1_col_r <= CW'(col_sel);
      f1_mag_r <= mag;
    end
    if (f2_adv) begin
      f2_ctl_r  <= f1_ctl_r;
      f2_addr_r <= addr;
      f2_term_r <= prod[WEIGHT_W +: TERM_W];
    end
  end

  assign push_valid = f2_valid_r;
  assign push_ctl   = f2_ctl_r;
  assign push_addr  = f2_addr_r;
  assign push_term  = f2_term_r;

endmodule

[hw/rtl/wia_queue.sv]
// Short queue of classified words between the front and back ends.
module wia_queue #(
  parameter int ADDR_W = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  wia_pkg::wia_ctl_t           push_ctl,
  input  logic [ADDR_W-1:0]           push_addr,
  input  logic [wia_pkg::TERM_W-1:0]  push_term,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output wia_pkg::wia_ctl_t           head_ctl,
  output logic [ADDR_W-1:0]           head_addr,
  output logic [wia_pkg::TERM_W-1:0]  head_term
);
  import wia_pkg::*;

  wia_ctl_t          ctl_q  [QUEUE_DEPTH];
  logic [ADDR_W-1:0] addr_q [QUEUE_DEPTH];
  logic [TERM_W-1:0] term_q [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wr_ptr_r]  <= push_ctl;
      addr_q[wr_ptr_r] <= push_addr;
      term_q[wr_ptr_r] <= push_term;
    end
  end

  assign head_ctl  = ctl_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];
  assign head_term = term_q[rd_ptr_r];

endmodule

[hw/rtl/wia_back.sv]
// Back end: intensity store, clearing pass, read-modify-write and result register.
module wia_back #(
  parameter int GRID_SIZE = 128
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  wia_pkg::wia_ctl_t                      head_ctl,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] head_addr,
  input  logic [wia_pkg::TERM_W-1:0]             head_term,
  output logic                                   clearing,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [wia_pkg::PIX_W-1:0]              out_pixel
);
  import wia_pkg::*;

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PIX_W-1:0] mem [DEPTH];

  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              b_valid_r, b_valid_nxt;
  wia_ctl_t          b_ctl_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic [TERM_W-1:0] b_term_r;
  logic [PIX_W-1:0]  rd_r;

  logic              fwd_valid_r, fwd_valid_nxt;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [PIX_W-1:0]  fwd_data_r;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r;

  logic              out_free, b_adv, wr_en, rd_load;
  logic [PIX_W-1:0]  cur, new_val;
  logic [PIX_W:0]    sum;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [PIX_W-1:0]  mem_wd;

  assign out_free = !out_valid_r || !out_stall;
  assign b_adv    = !b_valid_r || !b_ctl_r.is_read || out_free;
  assign q_pop    = b_adv && !q_empty;
  assign wr_en    = b_valid_r && !b_ctl_r.is_read;
  assign rd_load  = b_valid_r && b_ctl_r.is_read && out_free;

  // take the word just written if the read raced it
  assign cur = (fwd_valid_r && fwd_addr_r == b_addr_r) ? fwd_data_r : rd_r;
  assign sum = {1'b0, cur} + (PIX_W + 1)'(b_term_r);

  always_comb begin
    if (b_ctl_r.start) new_val = PIX_W'(b_term_r);
    else if (sum[PIX_W]) new_val = PIX_MAX;
    else new_val = sum[PIX_W-1:0];
  end

  always_comb begin
    if (clearing_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = b_addr_r;
      mem_wd = new_val;
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) clearing_nxt = 1'b0;
    end
    b_valid_nxt   = b_adv ? q_pop : b_valid_r;
    fwd_valid_nxt = b_adv ? wr_en : fwd_valid_r;
    if (rd_load) out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      b_valid_r   <= b_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (b_adv) rd_r <= mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_ctl_r    <= head_ctl;
      b_addr_r   <= head_addr;
      b_term_r   <= head_term;
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= new_val;
    end
    if (rd_load) out_pixel_r <= cur;
  end

  assign clearing  = clearing_r;
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the weighted intensity accumulator core.
`timescale 1ns / 1ps

module tb_top;

  localparam int GRID          = 128;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  // covers the clearing pass after reset with room to spare
  localparam int IDLE_LIMIT    = 50000;
  localparam bit REG_UNUSED    = 1'b1;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic                                 in_op;
  logic [wia_pkg::COORD_W-1:0]          in_row;
  logic [wia_pkg::COORD_W-1:0]          in_col;
  logic signed [wia_pkg::SAMP_W-1:0]    in_re;
  logic signed [wia_pkg::SAMP_W-1:0]    in_im;
  logic                                 in_start_req;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [wia_pkg::PIX_W-1:0]            out_pixel;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [wia_pkg::APB_ADDR_W-1:0]       paddr;
  logic [wia_pkg::APB_DATA_W-1:0]       pwdata;
  logic [wia_pkg::APB_DATA_W-1:0]       prdata;
  logic                                 pready;

  class intensity_scoreboard;
    bit [15:0]                 weight;
    bit [wia_pkg::PIX_W-1:0]   pixels [GRID*GRID];
    bit [wia_pkg::PIX_W-1:0]   expected_pixels [$];
    int                        mismatches;

    function int pending();
      return expected_pixels.size();
    endfunction

    function int slot_of(int r, int c);
      return (r % GRID) * GRID + (c % GRID);
    endfunction

    function void note_word(bit op, bit [6:0] row, bit [6:0] col,
                            bit signed [15:0] re, bit signed [15:0] im, bit start);
      longint                  energy;
      longint                  term;
      bit [wia_pkg::PIX_W:0]   sum;
      int                      slot;
      if (op == wia_pkg::OP_READ) begin
        // readout sees the quadrant-swapped pixel
        expected_pixels.push_back(pixels[slot_of(row + GRID / 2, col + GRID / 2)]);
        return;
      end
      energy = longint'(re) * re + longint'(im) * im;
      term = (longint'(weight) * energy) >> 16;
      slot = slot_of(row, col);
      if (start) begin
        pixels[slot] = term[wia_pkg::PIX_W-1:0];
      end else begin
        sum = pixels[slot] + term[wia_pkg::PIX_W-1:0];
        pixels[slot] = sum[wia_pkg::PIX_W] ? wia_pkg::PIX_MAX : sum[wia_pkg::PIX_W-1:0];
      end
    endfunction

    function void check_pixel(logic [wia_pkg::PIX_W-1:0] got);
      bit [wia_pkg::PIX_W-1:0] want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel word %h", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  intensity_scoreboard sb = new;

  bit        in_burst;
  bit        out_burst;
  bit        hold_off_req;
  bit [6:0]  pool_row [8];
  bit [6:0]  pool_col [8];

  weighted_intensity_accumulator_core #(.GRID_SIZE(GRID)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_re        (in_re),
    .in_im        (in_im),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'sh8001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word, after a random gap unless in a burst, and hold it until taken.
  task automatic send_word(bit op, bit [6:0] row, bit [6:0] col,
                           bit signed [15:0] re, bit signed [15:0] im, bit start);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_row       <= row;
    in_col       <= col;
    in_re        <= re;
    in_im        <= im;
    in_start_req <= start;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(op, row, col, re, im, start);
  endtask

  task automatic write_reg(bit idx, bit [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == wia_pkg::REG_WEIGHT) sb.weight = value;
    @(posedge clk);
  endtask

  // Drop valid, wait for every readout to return, then let accumulates retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = out_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_pixel(out_pixel);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit [15:0] phase_weight [5];
    bit [6:0]  r;
    bit [6:0]  c;
    bit        op;
    int        k;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= wia_pkg::OP_ACC;
    in_row       <= '0;
    in_col       <= '0;
    in_re        <= '0;
    in_im        <= '0;
    in_start_req <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // the store clears itself meanwhile; register writes still go through
    write_reg(wia_pkg::REG_WEIGHT, 16'hffff);
    write_reg(REG_UNUSED, 16'h5a5a);

    send_word(wia_pkg::OP_READ, 7'd0, 7'd0, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_ACC, 7'd0, 7'd0, 16'sh8000, 16'sh8000, 1'b0);
    send_word(wia_pkg::OP_ACC, 7'd127, 7'd127, 16'sh7fff, 16'sh8000, 1'b1);
    send_word(wia_pkg::OP_ACC, 7'd0, 7'd0, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_ACC, 7'd64, 7'd64, 16'sh0001, 16'shffff, 1'b0);
    // truncation takes this term to zero
    send_word(wia_pkg::OP_ACC, 7'd64, 7'd64, 16'shffff, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_ACC, 7'd127, 7'd0, 16'sh7fff, 16'sh7fff, 1'b1);
    send_word(wia_pkg::OP_READ, 7'd64, 7'd64, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd0, 7'd0, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd63, 7'd63, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd63, 7'd64, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd127, 7'd127, 16'sh0000, 16'sh0000, 1'b0);
    // repeated updates of one pixel, each after a random gap, then a read of it
    repeat (3) send_word(wia_pkg::OP_ACC, 7'd5, 7'd6, 16'sh1234, 16'shedcb, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd69, 7'd70, 16'sh0000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_ACC, 7'd5, 7'd6, 16'sh0064, -16'sh0064, 1'b1);
    send_word(wia_pkg::OP_READ, 7'd69, 7'd70, 16'shffff, 16'shffff, 1'b1);
    send_word(wia_pkg::OP_ACC, 7'd0, 7'd127, 16'sh8000, 16'sh0000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd64, 7'd63, 16'sh0000, 16'sh0000, 1'b0);

    wait_idle();
    write_reg(wia_pkg::REG_WEIGHT, 16'h0000);
    send_word(wia_pkg::OP_ACC, 7'd5, 7'd6, 16'sh8000, 16'sh8000, 1'b1);
    send_word(wia_pkg::OP_ACC, 7'd5, 7'd6, 16'sh7fff, 16'sh7fff, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd69, 7'd70, 16'sh0000, 16'sh0000, 1'b0);
    wait_idle();
    write_reg(wia_pkg::REG_WEIGHT, 16'h0001);
    send_word(wia_pkg::OP_ACC, 7'd64, 7'd64, 16'sh8000, 16'sh8000, 1'b0);
    send_word(wia_pkg::OP_READ, 7'd0, 7'd0, 16'sh0000, 16'sh0000, 1'b0);

    // random phases over a small pool of pixels so readouts hit live sums
    phase_weight = '{16'h0001, 16'h8000, 16'($urandom), 16'hffff, 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_reg(wia_pkg::REG_WEIGHT, phase_weight[ph]);
      for (int i = 0; i < 8; i++) begin
        pool_row[i] = 7'($urandom);
        pool_col[i] = 7'($urandom);
      end
      for (int n = 0; n < 60; n++) begin
        if (ph == 1 && n == 30) begin
          // stall the result side long enough for the block to back up
          hold_off_req = 1'b1;
          in_burst = 1'b1;
          for (int j = 0; j < 40; j++) begin
            k = $urandom_range(0, 7);
            send_word(wia_pkg::OP_READ, pool_row[k] + 7'd64, pool_col[k] + 7'd64,
                      pick_sample(), pick_sample(), 1'($urandom));
          end
          in_burst = 1'b0;
        end
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 4) == 0) begin
          r = 7'($urandom);
          c = 7'($urandom);
        end else begin
          r = pool_row[k];
          c = pool_col[k];
        end
        op = ($urandom_range(0, 99) < 35) ? wia_pkg::OP_READ : wia_pkg::OP_ACC;
        if (op == wia_pkg::OP_READ) begin
          r += 7'd64;
          c += 7'd64;
        end
        send_word(op, r, c, pick_sample(), pick_sample(), $urandom_range(0, 6) == 0);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      end
    end

    // pile near-full-scale terms onto one pixel until it saturates
    wait_idle();
    write_reg(wia_pkg::REG_WEIGHT, 16'hffff);
    r = 7'($urandom);
    c = 7'($urandom);
    for (int n = 0; n < 620; n++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(wia_pkg::OP_READ, r + 7'd64, c + 7'd64, pick_sample(), pick_sample(),
                  1'($urandom));
      else
        send_word(wia_pkg::OP_ACC, r, c,
                  $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff,
                  $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff, n == 0);
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
